[rtl/core/cbs_pkg.sv]
// Shared types and constants of the centered boxcar smoother.
package cbs_pkg;

    // Width and reset value of the half-width configuration register
    localparam int CFG_BITS = 4;
    localparam logic [CFG_BITS-1:0] HALF_WIDTH_RESET = 4'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_item;   // take one input transaction into the window
        logic start_pos;   // set up the window for the current position
        logic sum_step;    // add one window tap into the accumulator
        logic div_init;    // take the sum magnitude into the divider
        logic div_step;    // one restoring-division step
        logic out_load;    // round, sign and load the result register
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic emit;        // the item just loaded produces at least one result
        logic sum_done;    // the current tap is the last tap of the window
        logic div_done;    // the divider is on its last step
        logic more_pos;    // further positions remain in the final flush
        logic out_free;    // the result register can take a new value
    } sts_t;

endpackage

[rtl/core/cbs_ctrl.sv]
// Controller state machine of the centered boxcar smoother.
module cbs_ctrl import cbs_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SETUP,
        ST_SUM,
        ST_DIVINIT,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    // Command decode
    always_comb begin
        cmd           = '0;
        cmd.load_item = (state_reg == ST_IDLE) && in_valid;
        cmd.start_pos = (state_reg == ST_SETUP);
        cmd.sum_step  = (state_reg == ST_SUM);
        cmd.div_init  = (state_reg == ST_DIVINIT);
        cmd.div_step  = (state_reg == ST_DIV);
        cmd.out_load  = (state_reg == ST_OUT) && sts.out_free;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                state_next = sts.emit ? ST_SETUP : ST_IDLE;
            end
            ST_SETUP: begin
                state_next = ST_SUM;
            end
            ST_SUM: begin
                if (sts.sum_done) state_next = ST_DIVINIT;
            end
            ST_DIVINIT: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (sts.div_done) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (sts.out_free) state_next = sts.more_pos ? ST_SETUP : ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/core/cbs_datapath.sv]
// Datapath of the centered boxcar smoother: window taps, accumulator, divider, result register.
module cbs_datapath import cbs_pkg::*; #(
    parameter int MAX_HALF_WIDTH = 8,
    parameter int SAMPLE_BITS    = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [CFG_BITS-1:0]           cfg_wr_data,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    input  logic                          in_final,
    input  cmd_t                          cmd,
    output sts_t                          sts,
    output logic signed [SAMPLE_BITS-1:0] out_smoothed,
    output logic                          out_last,
    output logic                          out_valid,
    input  logic                          out_ready
);

    localparam int WinDepth = 2 * MAX_HALF_WIDTH + 1;
    localparam int CW = $clog2(WinDepth + 1);   // counts up to the window depth
    localparam int IW = $clog2(WinDepth);       // tap index
    localparam int SW = SAMPLE_BITS + CW;       // signed window sum
    localparam int MW = SW - 1;                 // sum magnitude, dividend bits
    localparam int DW = $clog2(MW + 1);         // division step counter
    localparam logic [CW-1:0] WinDepthC = CW'(WinDepth);
    localparam logic [CW-1:0] MaxHalfC  = CW'(MAX_HALF_WIDTH);

    logic [CFG_BITS-1:0]          half_width_reg;
    logic [SAMPLE_BITS-1:0]       win_reg [WinDepth];
    logic [CW-1:0]                seen_reg;
    logic [CW-1:0]                cnt_reg;
    logic [CW-1:0]                h_reg;
    logic                         fin_reg;
    logic [CW-1:0]                back_reg;
    logic [IW-1:0]                hi_reg;
    logic [IW-1:0]                idx_reg;
    logic signed [SW-1:0]         acc_reg;
    logic                         neg_reg;
    logic [MW-1:0]                quo_reg;
    logic [CW-1:0]                rem_reg;
    logic [CW-1:0]                div_reg;
    logic [DW-1:0]                dcnt_reg;
    logic [SAMPLE_BITS-1:0]       out_data_reg;
    logic                         out_last_reg;
    logic                         out_valid_reg;

    logic [CW-1:0]          h_eff;
    logic [CW-1:0]          seen_sat;
    logic [CW-1:0]          seen_sat_m1;
    logic [CW-1:0]          span;
    logic [CW-1:0]          cnt_m1;
    logic [CW-1:0]          hi_val;
    logic [SAMPLE_BITS-1:0] tap;
    logic signed [SW-1:0]   acc_abs;
    logic [CW:0]            rem_sh;
    logic                   rem_ge;
    logic                   round_up;
    logic [SAMPLE_BITS-1:0] quo_rnd;
    logic [SAMPLE_BITS-1:0] result;

    // Half width limited to MAX_HALF_WIDTH, the largest that the window store holds
    assign h_eff = (32'(half_width_reg) > 32'(MAX_HALF_WIDTH)) ? MaxHalfC
                                                               : CW'(half_width_reg);

    // Sample count of the waveform including the incoming sample, saturated at the window depth
    assign seen_sat    = (seen_reg == WinDepthC) ? WinDepthC : seen_reg + 1'b1;
    assign seen_sat_m1 = seen_sat - 1'b1;

    // Upper tap of the window for the current position; the lower tap is always 0
    assign span   = back_reg + h_reg;
    assign cnt_m1 = cnt_reg - 1'b1;
    assign hi_val = (span < cnt_m1) ? span : cnt_m1;

    assign tap     = win_reg[idx_reg];
    assign acc_abs = acc_reg[SW-1] ? -acc_reg : acc_reg;

    // Restoring division, one quotient bit per step
    assign rem_sh = {rem_reg, quo_reg[MW-1]};
    assign rem_ge = (rem_sh >= {1'b0, div_reg});

    // Round to nearest, ties away from zero, on the magnitude
    assign round_up = ({rem_reg, 1'b0} >= {1'b0, div_reg});
    assign quo_rnd  = quo_reg[SAMPLE_BITS-1:0] + SAMPLE_BITS'(round_up);
    assign result   = neg_reg ? -quo_rnd : quo_rnd;

    // Status to the controller
    always_comb begin
        sts          = '0;
        sts.emit     = fin_reg || (cnt_reg > h_reg);
        sts.sum_done = (idx_reg == hi_reg);
        sts.div_done = (dcnt_reg == DW'(1));
        sts.more_pos = fin_reg && (back_reg != '0);
        sts.out_free = !out_valid_reg || out_ready;
    end

    // Configuration register and waveform sample count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_width_reg <= HALF_WIDTH_RESET;
            seen_reg       <= '0;
        end else begin
            if (cfg_wr_en) half_width_reg <= cfg_wr_data;
            if (cmd.load_item) seen_reg <= in_final ? '0 : seen_sat;
        end
    end

    // Window shift line and per-item context
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            win_reg[0] <= in_sample;
            for (int i = 1; i < WinDepth; i++) begin
                win_reg[i] <= win_reg[i-1];
            end
            cnt_reg <= seen_sat;
            h_reg   <= h_eff;
            fin_reg <= in_final;
            if (in_final) begin
                back_reg <= (seen_sat_m1 < h_eff) ? seen_sat_m1 : h_eff;
            end else begin
                back_reg <= h_eff;
            end
        end else if (cmd.out_load && (back_reg != '0)) begin
            back_reg <= back_reg - 1'b1;
        end
    end

    // Window sum, one tap per cycle
    always_ff @(posedge aclk) begin
        if (cmd.start_pos) begin
            hi_reg  <= IW'(hi_val);
            idx_reg <= '0;
            acc_reg <= '0;
        end else if (cmd.sum_step) begin
            acc_reg <= acc_reg + {{(SW-SAMPLE_BITS){tap[SAMPLE_BITS-1]}}, tap};
            if (idx_reg != hi_reg) idx_reg <= idx_reg + 1'b1;
        end
    end

    // Divider of the sum magnitude by the window count
    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            neg_reg  <= acc_reg[SW-1];
            quo_reg  <= acc_abs[MW-1:0];
            rem_reg  <= '0;
            div_reg  <= CW'(hi_reg) + 1'b1;
            dcnt_reg <= DW'(MW);
        end else if (cmd.div_step) begin
            rem_reg  <= rem_ge ? CW'(rem_sh - {1'b0, div_reg}) : rem_sh[CW-1:0];
            quo_reg  <= {quo_reg[MW-2:0], rem_ge};
            dcnt_reg <= dcnt_reg - 1'b1;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= result;
            out_last_reg <= fin_reg && (back_reg == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_smoothed = out_data_reg;
    assign out_last     = out_last_reg;
    assign out_valid    = out_valid_reg;

endmodule

[rtl/core/centered_boxcar_smoother_top.sv]
// Top level of the centered boxcar smoother: controller, datapath and checks.
//
//  Channel  | Ports                          | Payload
//  ---------+--------------------------------+------------------------------------------
//  input    | s_tvalid s_tready s_tdata s_tlast | sample in tdata, final_sample in tlast
//  result   | m_tvalid m_tready m_tdata m_tlast | smoothed in tdata, last_out in tlast
//  config   | cfg_wr_en cfg_wr_data          | half_width, written when cfg_wr_en is high
//
//  An item is first loaded and decided on; then for each result it causes, hi+1 taps are
//  summed one per cycle, the restoring divider produces one quotient bit per cycle, and
//  the result is rounded, signed and loaded into the output register. The input is taken
//  only while the controller is idle. A finished result waits in the output register
//  while the next item is taken; a stalled result register holds the controller before
//  it loads the next result.
//  Reset is synchronous, active low; it clears the sample count and sets half_width to 3.
module centered_boxcar_smoother_top import cbs_pkg::*; #(
    parameter int MAX_HALF_WIDTH = 8,
    parameter int SAMPLE_BITS    = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [CFG_BITS-1:0]                   cfg_wr_data,  // half_width
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,      // sample
    input  logic                                  s_tlast,      // final_sample
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_tdata,      // smoothed
    output logic                                  m_tlast       // last_out
);

    localparam int DataBits = ((SAMPLE_BITS + 7) / 8) * 8;

    cmd_t                    cmd;
    sts_t                    sts;
    logic [SAMPLE_BITS-1:0]  smoothed;

    cbs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cbs_datapath #(
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_sample    (s_tdata[SAMPLE_BITS-1:0]),
        .in_final     (s_tlast),
        .cmd          (cmd),
        .sts          (sts),
        .out_smoothed (smoothed),
        .out_last     (m_tlast),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready)
    );

    // Zero-fill the result to whole bytes
    assign m_tdata = DataBits'(smoothed);

`ifndef SYNTHESIS
    // At most one datapath command per cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load_item, cmd.start_pos, cmd.sum_step,
                  cmd.div_init, cmd.div_step, cmd.out_load}))
        else $error("more than one datapath command in a cycle");

    // A result is loaded only into a free output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over a pending transaction");

    // An accepted input transaction makes the block busy in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an item is still in work");
`endif

endmodule

[tb/sv/centered_boxcar_smoother_top_test.sv]
// Self-checking testbench for the centered boxcar smoother: random stream traffic against a mean predictor.
`timescale 1ns / 100ps

module centered_boxcar_smoother_top_test;
    import cbs_pkg::*;

    localparam int MAX_HW        = 8;
    localparam int WIN_DEPTH     = 2 * MAX_HW + 1;
    localparam int DATA_W        = 16;
    localparam int SETTLE_CYCLES = 64;   // block idle time before a half_width write
    localparam int TAIL_CYCLES   = 100;  // covers one full result computation
    localparam int RAND_ITEMS    = 140;
    localparam int PRINT_CAP     = 100;

    typedef enum logic [1:0] {FEED_SAMPLE, FEED_HALF_WIDTH, FEED_SETTLE} feed_kind_t;

    typedef struct {
        feed_kind_t          kind;
        logic [DATA_W-1:0]   sample;
        logic                fin;
        logic [CFG_BITS-1:0] hw;
    } feed_t;

    typedef struct {
        logic [DATA_W-1:0] smoothed;
        logic              last_out;
    } smooth_res_t;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [CFG_BITS-1:0] cfg_wr_data = '0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata     = '0;
    logic                s_tlast     = 1'b0;
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [DATA_W-1:0]   m_tdata;
    logic                m_tlast;

    // Stimulus and expectations
    feed_t       feed_q[$];
    smooth_res_t smoothed_q[$];
    int unsigned mismatch_count = 0;

    // Predictor state: newest sample at index 0
    logic signed [DATA_W-1:0] win_q [WIN_DEPTH];
    int unsigned              seen_cnt;
    logic [CFG_BITS-1:0]      half_cfg;

    // Driver and receiver bookkeeping
    logic        in_taken   = 1'b0;
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;
    int unsigned idle_run   = 0;
    int unsigned rx_left    = 0;
    int unsigned rx_mode    = 0;

    centered_boxcar_smoother_top #(
        .MAX_HALF_WIDTH (MAX_HW),
        .SAMPLE_BITS    (DATA_W)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),  // half_width
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),      // sample
        .s_tlast     (s_tlast),      // final_sample
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),      // smoothed
        .m_tlast     (m_tlast)       // last_out
    );

    always #5 aclk = ~aclk;

    task automatic report_mismatch(string msg);
        if (mismatch_count < PRINT_CAP)
            $display("%0t ns: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Mean of the window centred 'back' samples behind the newest one, clipped to what exists
    function automatic logic [DATA_W-1:0] boxcar_mean(int unsigned back, int unsigned h);
        int unsigned       lo, hi, cnt, d;
        longint            acc;
        longint unsigned   mag, q;
        lo = (back > h) ? back - h : 0;
        hi = back + h;
        if (hi >= seen_cnt) hi = seen_cnt - 1;
        if (hi >= WIN_DEPTH) hi = WIN_DEPTH - 1;
        if (lo > hi) lo = hi;
        acc = 0;
        for (d = lo; d <= hi; d++) acc += win_q[d];
        cnt = hi - lo + 1;
        mag = (acc < 0) ? -acc : acc;
        // round to nearest, ties away from zero
        q = (2 * mag + cnt) / (2 * cnt);
        return (acc < 0) ? DATA_W'(-q) : DATA_W'(q);
    endfunction

    // Shift one accepted sample into the window and queue the means it releases
    task automatic smooth_sample(logic [DATA_W-1:0] x, logic fin);
        int unsigned h, top, back, i;
        h = (half_cfg > MAX_HW) ? MAX_HW : half_cfg;
        for (i = WIN_DEPTH - 1; i > 0; i--) win_q[i] = win_q[i-1];
        win_q[0] = x;
        if (seen_cnt < WIN_DEPTH) seen_cnt++;
        if (!fin) begin
            if (seen_cnt > h) smoothed_q.push_back('{boxcar_mean(h, h), 1'b0});
        end else begin
            // flush the trailing positions, oldest first
            top = (seen_cnt - 1 > h) ? h : seen_cnt - 1;
            for (i = 0; i <= top; i++) begin
                back = top - i;
                smoothed_q.push_back('{boxcar_mean(back, h), back == 0});
            end
            seen_cnt = 0;
        end
    endtask

    task automatic push_sample(logic [DATA_W-1:0] x, logic fin);
        feed_q.push_back('{kind: FEED_SAMPLE, sample: x, fin: fin, hw: '0});
    endtask

    task automatic push_half_width(logic [CFG_BITS-1:0] v);
        feed_q.push_back('{kind: FEED_HALF_WIDTH, sample: '0, fin: 1'b0, hw: v});
    endtask

    function automatic logic [DATA_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return DATA_W'($urandom_range(0, 8) - 4);
            3: return 16'hFFFF;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_BITS-1:0] rand_half_width();
        case ($urandom_range(0, 5))
            0: return 4'd0;
            1: return 4'd8;
            2: return 4'd15;
            default: return CFG_BITS'($urandom_range(0, 15));
        endcase
    endfunction

    // Input and result monitor: predicts on every accepted sample, checks every result
    always @(posedge aclk) begin
        smooth_res_t want;
        if (!aresetn) begin
            seen_cnt = 0;
            half_cfg = HALF_WIDTH_RESET;
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_tvalid && s_tready;
            if (cfg_wr_en) half_cfg = cfg_wr_data;
            if (s_tvalid && s_tready) smooth_sample(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (smoothed_q.size() == 0) begin
                    report_mismatch($sformatf("result %h/%b with nothing expected",
                                              m_tdata, m_tlast));
                end else begin
                    want = smoothed_q.pop_front();
                    if (m_tdata !== want.smoothed)
                        report_mismatch($sformatf("smoothed %h, expected %h",
                                                  m_tdata, want.smoothed));
                    if (m_tlast !== want.last_out)
                        report_mismatch($sformatf("last_out %b, expected %b",
                                                  m_tlast, want.last_out));
                end
            end
        end
    end

    // Sender: bursts of transactions with random gaps; config writes only once the block is idle
    always @(negedge aclk) begin
        feed_t nxt;
        logic  nxt_valid;
        logic  nxt_cfg;
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            cfg_wr_en <= 1'b0;
        end else if (s_tvalid && !in_taken) begin
            idle_run = 0;   // hold the current transaction
        end else begin
            nxt_valid = 1'b0;
            nxt_cfg   = 1'b0;
            if (smoothed_q.size() == 0 && !s_tvalid) idle_run++;
            else idle_run = 0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (feed_q.size() != 0) begin
                nxt = feed_q[0];
                if (nxt.kind == FEED_SAMPLE) begin
                    feed_q.delete(0);
                    s_tdata   <= nxt.sample;
                    s_tlast   <= nxt.fin;
                    nxt_valid = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 16);
                        case ($urandom_range(0, 3))
                            0: gap_left = 0;
                            1: gap_left = $urandom_range(1, 3);
                            2: gap_left = $urandom_range(4, 12);
                            default: gap_left = $urandom_range(0, 30);
                        endcase
                    end else begin
                        burst_left--;
                    end
                end else if (idle_run >= SETTLE_CYCLES) begin
                    feed_q.delete(0);
                    idle_run = 0;
                    if (nxt.kind == FEED_HALF_WIDTH) begin
                        nxt_cfg = 1'b1;
                        cfg_wr_data <= nxt.hw;
                    end
                end
            end
            s_tvalid  <= nxt_valid;
            cfg_wr_en <= nxt_cfg;
        end
    end

    // Receiver: switches among always-ready, random, mostly-stalled and toggling patterns
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(8, 80);
            end else begin
                rx_left--;
            end
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 7) == 0);
                default: m_tready <= rx_left[1];
            endcase
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int unsigned rand_items;
        int unsigned wave_len;
        int unsigned i;

        // one-sample waveform at the reset half width
        push_sample(16'h8000, 1'b1);
        // rounding ties of both signs at the clipped edges
        push_half_width(4'd1);
        push_sample(16'd3, 1'b0);
        push_sample(16'd0, 1'b0);
        push_sample(-16'sd3, 1'b1);
        // zero half width passes samples through
        push_half_width(4'd0);
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'hFFFF, 1'b1);
        // half width above the limit saturates; full nine-result flush of extremes
        push_half_width(4'd15);
        for (i = 0; i < 10; i++) push_sample(i[0] ? 16'h8000 : 16'h7FFF, i == 9);
        // half width changed in the middle of a waveform
        push_half_width(4'd2);
        push_sample(16'd100, 1'b0);
        push_sample(16'd200, 1'b0);
        push_sample(16'd300, 1'b0);
        push_half_width(4'd6);
        push_sample(16'd400, 1'b0);
        push_sample(16'd500, 1'b1);
        push_half_width(4'd8);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h8000, 1'b1);

        // random waveforms, mostly short, with occasional retuning
        rand_items = 0;
        while (rand_items < RAND_ITEMS) begin
            case ($urandom_range(0, 9))
                0: wave_len = $urandom_range(1, 3);
                1, 2: wave_len = $urandom_range(25, 40);
                default: wave_len = $urandom_range(4, 24);
            endcase
            for (i = 0; i < wave_len; i++) begin
                push_sample(rand_sample(), i == wave_len - 1);
                rand_items++;
                if (i < wave_len - 1 && $urandom_range(0, 29) == 0)
                    push_half_width(rand_half_width());
            end
            if ($urandom_range(0, 3) == 0)
                push_half_width(rand_half_width());
            else if ($urandom_range(0, 9) == 0)
                feed_q.push_back('{kind: FEED_SETTLE, sample: '0, fin: 1'b0, hw: '0});
        end

        repeat (7) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        while (feed_q.size() != 0 || s_tvalid) @(posedge aclk);
        while (smoothed_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog: 8 ms, far beyond the slowest legal run
    initial begin
        #8_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
rtl/core/cbs_pkg.sv
rtl/core/cbs_ctrl.sv
rtl/core/cbs_datapath.sv
rtl/core/centered_boxcar_smoother_top.sv
tb/sv/centered_boxcar_smoother_top_test.sv
